[rtl/char_lcd_nibble_writer_defines.svh]
// assertion macros for the character lcd nibble writer
// used by the top level only, no other dependencies
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define LCDNW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcdnw assertion failed");

// next-cycle implication, checked while out of reset
`define LCDNW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcdnw assertion failed");

`endif

[rtl/lcdnw_pkg.sv]
// shared types, codes and constants for the character lcd nibble writer
// no dependencies
`default_nettype none

package lcdnw_pkg;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_CMD  = 2'd1,
        ACT_DATA = 2'd2,
        ACT_POS  = 2'd3
    } action_t;

    localparam logic [1:0] CFG_PULSE    = 2'd0;
    localparam logic [1:0] CFG_POWER_UP = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    localparam logic [7:0] PULSE_RST    = 8'd1;
    localparam logic [7:0] POWER_UP_RST = 8'd15;
    localparam logic [7:0] GAP_RST      = 8'd5;

    localparam logic [1:0] ROW_ONE      = 2'd1;
    localparam logic [7:0] ROW_TWO_BASE = 8'h40;
    localparam logic [7:0] SET_DDRAM    = 8'h80;

    localparam int QUEUE_DEPTH = 2;

    localparam int INIT_RESULTS = 26;
    localparam int STEP_W       = $clog2(INIT_RESULTS);
    localparam logic [STEP_W-1:0] STEP_POWER_UP  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_FIRST_END = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_GAP       = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_TAIL      = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_BYTE_LAST = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = STEP_W'(INIT_RESULTS - 1);

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [7:0] pulse_ms;
        logic [7:0] power_up_ms;
        logic [7:0] init_gap_ms;
    } cfg_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h03;
            3'd1: b = 8'h02;
            3'd2: b = 8'h28;
            3'd3: b = 8'h0C;
            3'd4: b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/char_lcd_nibble_writer.sv]
// top level of the character lcd nibble writer: config registers, front, queue, sequencer
// depends on lcdnw_pkg, lcdnw_front, lcdnw_queue, lcdnw_back and the defines header
//
// Each request expands into timed pin phases, one result per clock while m_ready is high:
// command, data and cursor requests give 4 results, initialise gives 26. The
// sequencer's single output register sets that pace, one phase per cycle. The running
// operation stays at the head of the two-entry queue until its last phase is produced, so
// the free queue entry and the front register let up to two further requests be taken
// while a run is being sent out; after that s_ready drops until the run's last phase is
// produced. hold_ms is taken from the timing registers as each phase is produced; write
// them only while no request is in flight.
`default_nettype none
`include "char_lcd_nibble_writer_defines.svh"

module char_lcd_nibble_writer
    import lcdnw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    input  wire logic [7:0] s_value,
    input  wire logic [1:0] s_row,
    input  wire logic [6:0] s_col,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_reg_select,
    output logic [3:0]      m_data_nibble,
    output logic            m_enable,
    output logic [7:0]      m_hold_ms,
    output logic            m_last
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic fr_valid;
    op_t  fr_op;
    logic q_ready;
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_PULSE:    cfg_next.pulse_ms    = cfg_wdata;
                CFG_POWER_UP: cfg_next.power_up_ms = cfg_wdata;
                CFG_GAP:      cfg_next.init_gap_ms = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ms    <= PULSE_RST;
            cfg_reg.power_up_ms <= POWER_UP_RST;
            cfg_reg.init_gap_ms <= GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcdnw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_value  (s_value),
        .s_row    (s_row),
        .s_col    (s_col),
        .fr_valid (fr_valid),
        .fr_op    (fr_op),
        .q_ready  (q_ready)
    );

    lcdnw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fr_valid),
        .push_op    (fr_op),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_op)
    );

    lcdnw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_valid    (q_valid),
        .head_op       (q_op),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_select  (m_reg_select),
        .m_data_nibble (m_data_nibble),
        .m_enable      (m_enable),
        .m_hold_ms     (m_hold_ms),
        .m_last        (m_last)
    );

    // an accepted request always lands in the front register
    `LCDNW_ASSERT_NEXT(a_front_load, aclk, aresetn, s_valid && s_ready, fr_valid)
    // a run is never cut short: the next phase follows each non-last result at once
    `LCDNW_ASSERT_NEXT(a_run_held, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)
    // a strobe-high phase is followed by the falling phase of the same nibble
    `LCDNW_ASSERT_NEXT(a_strobe_fall, aclk, aresetn, m_valid && m_ready && m_enable,
        m_valid && !m_enable && $stable(m_data_nibble) && $stable(m_reg_select))

endmodule

`default_nettype wire

[rtl/lcdnw_front.sv]
// front stage: takes a request, turns it into a queued byte or init operation
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_front
    import lcdnw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    input  wire logic [7:0] s_value,
    input  wire logic [1:0] s_row,
    input  wire logic [6:0] s_col,
    output logic            fr_valid,
    output op_t             fr_op,
    input  wire logic       q_ready
);

    logic fr_valid_reg;
    logic fr_valid_next;
    op_t  fr_op_reg;
    op_t  op_next;
    logic [7:0] addr;
    logic accept;

    always_comb begin
        addr = {1'b0, s_col} - 8'd1;
        if (s_row != ROW_ONE) begin
            addr = addr + ROW_TWO_BASE;
        end
        addr = addr + SET_DDRAM;
    end

    always_comb begin
        op_next = '0;
        case (action_t'(s_action))
            ACT_INIT: begin
                op_next.is_init = 1'b1;
            end
            ACT_CMD: begin
                op_next.data = s_value;
            end
            ACT_DATA: begin
                op_next.rs   = 1'b1;
                op_next.data = s_value;
            end
            ACT_POS: begin
                op_next.data = addr;
            end
            default: begin
                op_next = '0;
            end
        endcase
    end

    assign s_ready = !fr_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (accept) begin
            fr_valid_next = 1'b1;
        end else if (q_ready) begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_op_reg <= op_next;
        end
    end

    assign fr_valid = fr_valid_reg;
    assign fr_op    = fr_op_reg;

endmodule

`default_nettype wire

[rtl/lcdnw_queue.sv]
// short operation queue between the front stage and the sequencer
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_queue
    import lcdnw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  op_t       push_op,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output op_t       head_op
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

[rtl/lcdnw_back.sv]
// back end sequencer: steps through the pin phases of the head operation
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_back
    import lcdnw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  cfg_t            cfg,
    input  wire logic       head_valid,
    input  op_t             head_op,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_reg_select,
    output logic [3:0]      m_data_nibble,
    output logic            m_enable,
    output logic [7:0]      m_hold_ms,
    output logic            m_last
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] tail_step;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_rs_reg;
    logic [3:0]        m_nib_reg;
    logic              m_en_reg;
    logic [7:0]        m_hold_reg;
    logic              m_last_reg;
    logic              pin_rs_reg;
    logic [3:0]        pin_nib_reg;
    logic              pin_en_reg;

    logic       emit;
    logic       is_delay;
    logic       is_last;
    logic [1:0] phase;
    logic [7:0] cur_byte;
    logic [7:0] hold;
    logic       out_rs;
    logic [3:0] out_nib;
    logic       out_en;

    always_comb begin
        tail_step = step_reg - STEP_TAIL;
        is_delay  = 1'b0;
        phase     = step_reg[1:0];
        cur_byte  = head_op.data;
        hold      = cfg.pulse_ms;
        is_last   = (step_reg == STEP_BYTE_LAST);
        if (head_op.is_init) begin
            is_last = (step_reg == STEP_INIT_LAST);
            if (step_reg == STEP_POWER_UP) begin
                is_delay = 1'b1;
                hold     = cfg.power_up_ms;
            end else if (step_reg <= STEP_FIRST_END) begin
                phase    = 2'(step_reg - 1'b1);
                cur_byte = init_byte(3'd0);
            end else if (step_reg == STEP_GAP) begin
                is_delay = 1'b1;
                hold     = cfg.init_gap_ms;
            end else begin
                phase    = tail_step[1:0];
                cur_byte = init_byte(3'd1 + tail_step[4:2]);
            end
        end
        if (is_delay) begin
            out_rs  = pin_rs_reg;
            out_nib = pin_nib_reg;
            out_en  = pin_en_reg;
        end else begin
            out_rs  = head_op.rs;
            out_nib = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
            out_en  = !phase[0];
        end
    end

    assign emit = head_valid && (!m_valid_reg || m_ready);
    assign pop  = emit && is_last;

    always_comb begin
        step_next = step_reg;
        if (emit) begin
            step_next = is_last ? '0 : step_reg + 1'b1;
        end
        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            pin_rs_reg  <= 1'b0;
            pin_nib_reg <= '0;
            pin_en_reg  <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (emit) begin
                pin_rs_reg  <= out_rs;
                pin_nib_reg <= out_nib;
                pin_en_reg  <= out_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_rs_reg   <= out_rs;
            m_nib_reg  <= out_nib;
            m_en_reg   <= out_en;
            m_hold_reg <= hold;
            m_last_reg <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_select  = m_rs_reg;
    assign m_data_nibble = m_nib_reg;
    assign m_enable      = m_en_reg;
    assign m_hold_ms     = m_hold_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire
